@@ hw/rtl/downmix_linear_resampler_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the downmix linear resampler checks
// ---------------------------------------------------------------------------
`ifndef DOWNMIX_LINEAR_RESAMPLER_ASSERT_SVH
`define DOWNMIX_LINEAR_RESAMPLER_ASSERT_SVH

// Clocked check, ignored while reset is held
`define DLR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("downmix resampler check failed");

// Clocked check that also covers the reset cycles
`define DLR_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("downmix resampler reset check failed");

`endif

@@ hw/rtl/dlr_pkg.sv @@
// ---------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants of the downmix linear resampler.
// ---------------------------------------------------------------------------
package dlr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 4;
  localparam int PHASE_W  = 21;
  // Working phase carries one extra bit while the step is being added
  localparam int PHASE_X_W = PHASE_W + 1;

  localparam logic [PHASE_X_W-1:0] ONE_Q16      = 22'h010000;
  localparam logic [PHASE_W-1:0]   MIN_STEP     = 21'd4096;
  localparam logic [PHASE_W-1:0]   STEP_RESET   = 21'd196608;
  localparam logic [COUNT_W-1:0]   COUNT_RESET  = 4'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [0:0] REG_RESAMPLE_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DINIT,
    ST_DIV,
    ST_MONO,
    ST_MUL,
    ST_EMIT,
    ST_FIN
  } dlr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic sum_en;
    logic div_init;
    logic div_step;
    logic mono_load;
    logic mul;
    logic emit;
    logic finish;
  } dlr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [COUNT_W-1:0] cnt_eff;
    logic               phase_ge_one;
    logic               last;
    logic               out_free;
  } dlr_sts_t;

endpackage

@@ hw/rtl/dlr_ctrl.sv @@
// ---------------------------------------------------------------------------
// dlr_ctrl
// Sequencer: sums the channels, runs the divider, then walks the phase
// through interpolation steps and retires the frame.
// ---------------------------------------------------------------------------
module dlr_ctrl #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dlr_pkg::dlr_sts_t sts,
  output dlr_pkg::dlr_cmd_t cmd
);

  localparam int SUM_W = dlr_pkg::SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int CNT_W = $clog2(SUM_W + 1);

  dlr_pkg::dlr_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlr_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      dlr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = dlr_pkg::ST_SUM;
          cnt_nxt   = CNT_W'(sts.cnt_eff);
        end
      end
      dlr_pkg::ST_SUM: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = dlr_pkg::ST_DINIT;
        end
      end
      dlr_pkg::ST_DINIT: begin
        state_nxt = dlr_pkg::ST_DIV;
        cnt_nxt   = CNT_W'(SUM_W);
      end
      dlr_pkg::ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = dlr_pkg::ST_MONO;
        end
      end
      dlr_pkg::ST_MONO: begin
        state_nxt = sts.phase_ge_one ? dlr_pkg::ST_FIN : dlr_pkg::ST_MUL;
      end
      dlr_pkg::ST_MUL: begin
        state_nxt = dlr_pkg::ST_EMIT;
      end
      dlr_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.last ? dlr_pkg::ST_FIN : dlr_pkg::ST_MUL;
        end
      end
      dlr_pkg::ST_FIN: begin
        state_nxt = dlr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dlr_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      dlr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      dlr_pkg::ST_SUM:   cmd.sum_en    = 1'b1;
      dlr_pkg::ST_DINIT: cmd.div_init  = 1'b1;
      dlr_pkg::ST_DIV:   cmd.div_step  = 1'b1;
      dlr_pkg::ST_MONO:  cmd.mono_load = 1'b1;
      dlr_pkg::ST_MUL:   cmd.mul       = 1'b1;
      dlr_pkg::ST_EMIT:  cmd.emit      = sts.out_free;
      dlr_pkg::ST_FIN:   cmd.finish    = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/dlr_datapath.sv @@
// ---------------------------------------------------------------------------
// dlr_datapath
// Channel store, accumulator, bit-serial divider, interpolation multiplier,
// phase accumulator, configuration registers and output register.
// ---------------------------------------------------------------------------
module dlr_datapath #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic [dlr_pkg::SAMPLE_W*MAX_CHANNELS-1:0]  in_tdata,
  input  logic                                       cfg_wr_en,
  input  logic [0:0]                                 cfg_index,
  input  logic [dlr_pkg::PHASE_W-1:0]                cfg_wdata,
  input  dlr_pkg::dlr_cmd_t                          cmd,
  output dlr_pkg::dlr_sts_t                          sts,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [dlr_pkg::SAMPLE_W-1:0]               out_tdata,
  output logic                                       out_tlast
);

  localparam int SW    = dlr_pkg::SAMPLE_W;
  localparam int SUM_W = SW + $clog2(MAX_CHANNELS);
  localparam int PX_W  = dlr_pkg::PHASE_X_W;

  logic [dlr_pkg::COUNT_W-1:0] count_r;
  logic [dlr_pkg::PHASE_W-1:0] step_r;
  logic signed [SW-1:0]        chan_r [MAX_CHANNELS];
  logic signed [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]            quo_r;
  logic [3:0]                  rem_r;
  logic                        neg_r;
  logic signed [SW-1:0]        mono_r;
  logic signed [SW-1:0]        prev_r;
  logic [PX_W-1:0]             phase_r;
  logic signed [2*SW+1:0]      prod_r;
  logic                        out_valid_r;
  logic [SW-1:0]               out_data_r;
  logic                        out_last_r;

  logic [dlr_pkg::COUNT_W-1:0] cnt_eff;
  logic [dlr_pkg::PHASE_W-1:0] step_eff;
  logic [PX_W-1:0]             phase_step;
  logic [4:0]                  rem_sh;
  logic [4:0]                  divisor;
  logic                        rem_ge;
  logic signed [SW:0]          diff;
  logic signed [SW:0]          frac;
  logic signed [SW+1:0]        interp;

  // Clamp the configuration to its usable range
  always_comb begin
    priority if (count_r == '0) begin
      cnt_eff = dlr_pkg::COUNT_W'(1);
    end else if (count_r > dlr_pkg::COUNT_W'(MAX_CHANNELS)) begin
      cnt_eff = dlr_pkg::COUNT_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = count_r;
    end
  end

  assign step_eff   = (step_r < dlr_pkg::MIN_STEP) ? dlr_pkg::MIN_STEP : step_r;
  assign phase_step = phase_r + {1'b0, step_eff};

  // One restoring divide step: remainder stays below the divisor
  assign divisor = {1'b0, cnt_eff};
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_ge  = (rem_sh >= divisor);

  // Interpolation terms
  assign diff   = {mono_r[SW-1], mono_r} - {prev_r[SW-1], prev_r};
  assign frac   = $signed({1'b0, phase_r[SW-1:0]});
  assign interp = (SW+2)'(prod_r >>> SW) + (SW+2)'(prev_r);

  assign sts.cnt_eff      = cnt_eff;
  assign sts.phase_ge_one = (phase_r >= dlr_pkg::ONE_Q16);
  assign sts.last         = (phase_step >= dlr_pkg::ONE_Q16);
  assign sts.out_free     = !out_valid_r || out_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= dlr_pkg::COUNT_RESET;
      step_r  <= dlr_pkg::STEP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dlr_pkg::REG_CHANNEL_COUNT: count_r <= cfg_wdata[dlr_pkg::COUNT_W-1:0];
        dlr_pkg::REG_RESAMPLE_STEP: step_r  <= cfg_wdata;
        default: begin
          step_r <= step_r;
        end
      endcase
    end
  end

  // Capture the frame, then shift one channel a cycle into the accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        chan_r[i] <= in_tdata[SW*i +: SW];
      end
      sum_r <= '0;
    end else if (cmd.sum_en) begin
      for (int i = 0; i < MAX_CHANNELS - 1; i++) begin
        chan_r[i] <= chan_r[i+1];
      end
      sum_r <= sum_r + SUM_W'(chan_r[0]);
    end
  end

  // Divide the magnitude by the channel count, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_r <= sum_r[SUM_W-1];
      quo_r <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? 4'(rem_sh - divisor) : rem_sh[3:0];
      quo_r <= {quo_r[SUM_W-2:0], rem_ge};
    end
  end

  // Apply the sign: truncation toward zero
  always_ff @(posedge clk) begin
    if (cmd.mono_load) begin
      mono_r <= neg_r ? SW'(-quo_r) : quo_r[SW-1:0];
    end
  end

  // Register the interpolation product
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= frac * diff;
    end
  end

  // Phase accumulator and previous sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      prev_r  <= '0;
    end else if (cmd.emit) begin
      phase_r <= phase_step;
    end else if (cmd.finish) begin
      phase_r <= {1'b0, dlr_pkg::PHASE_W'(phase_r - dlr_pkg::ONE_Q16)};
      prev_r  <= mono_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= interp[SW-1:0];
      out_last_r <= sts.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/downmix_linear_resampler.sv @@
// ---------------------------------------------------------------------------
// downmix_linear_resampler
// Averages the active channels of each frame to mono and resamples the mono
// stream by linear interpolation under a Q5.16 phase accumulator.
// ---------------------------------------------------------------------------
//  channel  direction  word contents
//  in_      slave      tdata: chan0 .. chan7, 16 bits each, chan0 lowest
//  out_     master     tdata: mono_out; tlast: last result of the frame
//  cfg_     write      index 0 channel_count, index 1 resample_step
//
// A frame runs from acceptance to the next ready through these steps: one
// channel added per cycle, the bit-serial divider over SUM_W = 16 +
// log2(MAX_CHANNELS) bits (19 at the default), then a multiply step and an
// emit step for each result through the shared multiplier.
// A frame is accepted only while the sequencer is idle; the last result may
// still sit in the output register then.
// A stalled output holds the sequencer in its emit step.
// Reset needs no clearing pass.
// ---------------------------------------------------------------------------
module downmix_linear_resampler #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // chan0 [15:0], chan1 [31:16], ... one 16-bit field per channel
  input  logic [dlr_pkg::SAMPLE_W*MAX_CHANNELS-1:0] in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // mono_out [15:0]
  output logic [dlr_pkg::SAMPLE_W-1:0]              out_tdata,
  output logic                                      out_tlast,
  input  logic                                      cfg_wr_en,
  input  logic [0:0]                                cfg_index,
  input  logic [dlr_pkg::PHASE_W-1:0]               cfg_wdata
);

  dlr_pkg::dlr_cmd_t cmd;
  dlr_pkg::dlr_sts_t sts;

  dlr_ctrl #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dlr_datapath #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hw/rtl/dlr_checker.sv @@
// ---------------------------------------------------------------------------
// dlr_checker
// Port-level checks of the downmix linear resampler, bound to the top level.
// ---------------------------------------------------------------------------
`include "downmix_linear_resampler_assert.svh"

module dlr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // Whole output word, data and last flag together
  logic [16:0] out_word;

  assign out_word = {out_tlast, out_tdata};

  // Hold a stalled result
  `DLR_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `DLR_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_word))
  // Drop ready for the frame in flight
  `DLR_ASSERT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  // Come out of reset idle with an empty output register
  `DLR_ASSERT_RST(a_reset_idle, clk, !rst_n |=> in_tready && !out_tvalid)

endmodule

bind downmix_linear_resampler dlr_checker u_dlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ sim/downmix_linear_resampler_tb.sv @@
// ---------------------------------------------------------------------------
// downmix_linear_resampler_tb
// Self-checking bench for the downmix linear resampler. A directed table of
// frames and register settings runs first, then random frames under changing
// settings. Each accepted frame goes through an in-bench downmix and phase
// accumulator model, and every output word is compared with the oldest
// predicted sample. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module downmix_linear_resampler_tb;

  localparam int SAMPLE_W    = dlr_pkg::SAMPLE_W;
  localparam int COUNT_W     = dlr_pkg::COUNT_W;
  localparam int PHASE_W     = dlr_pkg::PHASE_W;
  localparam int MAX_CH      = 8;
  localparam int FRAME_W     = SAMPLE_W * MAX_CH;
  localparam int MAX_RESULTS = 16;
  localparam int DRAIN_CYC   = 100;
  localparam int RAND_ITEMS  = 500;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mono;
    logic                last;
  } mono_sample_t;

  typedef enum logic {ROW_FRAME, ROW_CONFIG} row_kind_t;

  // One directed step: a frame, or a new pair of register values.
  // n_fixed < 0 means the predictor supplies the expected samples.
  typedef struct packed {
    row_kind_t           kind;
    logic [COUNT_W-1:0]  count;
    logic [PHASE_W-1:0]  step;
    logic [FRAME_W-1:0]  frame;
    logic signed [7:0]   n_fixed;
    logic [SAMPLE_W-1:0] fixed_mono;
  } stim_row_t;

  localparam logic signed [7:0] BY_MODEL = -8'sd1;
  localparam int N_DIR = 22;

  // Frames are written chan7 (left) down to chan0 (right)
  localparam stim_row_t DIRECTED [N_DIR] = '{
    // reset settings: two channels, step 3.0; first sample is the reset prev
    '{ROW_FRAME, 4'd0, 21'd0, 128'h0000_0000_0000_0000_0000_0000_07D0_03E8, 8'sd1, 16'h0000},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h0001_8000_7FFF_5555_AAAA_FFFF_7FFF_8000, 8'sd0, 16'h0000},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h0000_0000_0000_0000_0000_0000_7FFF_7FFF, 8'sd0, 16'h0000},
    // phase back at zero: emits the full-scale positive mono of the last frame
    '{ROW_FRAME, 4'd0, 21'd0, 128'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_8000_8000, 8'sd1, 16'h7FFF},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h0000_0000_0000_0000_0000_0000_0002_0005, 8'sd0, 16'h0000},
    // -3 / 2 truncates toward zero to -1
    '{ROW_FRAME, 4'd0, 21'd0, 128'h0000_0000_0000_0000_0000_0000_0000_FFFD, 8'sd0, 16'h0000},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h0000_0000_0000_0000_0000_0000_8000_7FFF, 8'sd1, 16'hFFFF},
    // count 0 acts as 1, step below the floor acts as 1/16: sixteen samples
    '{ROW_CONFIG, 4'd0, 21'd4095, 128'h0, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h8000_8000_8000_8000_8000_8000_8000_8000, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h8000_8000_8000_8000_8000_8000_8000_7FFF, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h7FFF_7FFF_7FFF_7FFF_7FFF_7FFF_7FFF_8000, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h0000_0000_0000_0000_0000_0000_0000_7FFF, BY_MODEL, 16'h0},
    // step of exactly one: one sample per frame
    '{ROW_CONFIG, 4'd3, 21'd65536, 128'h0, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h0000_0000_0000_0000_0000_7FFF_7FFF_7FFF, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h7FFF_7FFF_7FFF_7FFF_7FFF_8000_8000_8000, BY_MODEL, 16'h0},
    // all eight channels, step 16.0
    '{ROW_CONFIG, 4'd8, 21'd1048576, 128'h0, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h7FFF_7FFF_7FFF_7FFF_7FFF_7FFF_7FFF_7FFF, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h8000_8000_8000_8000_8000_8000_8000_8000, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h1234_FEDC_0F0F_F0F0_5555_AAAA_0001_FFFF, BY_MODEL, 16'h0},
    // count above eight clamps, step above 16.0 is kept as written
    '{ROW_CONFIG, 4'd15, 21'h1FFFFF, 128'h0, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'hAAAA_5555_8000_7FFF_0000_FFFF_C000_4000, BY_MODEL, 16'h0},
    '{ROW_FRAME, 4'd0, 21'd0, 128'h5555_AAAA_7FFF_8000_FFFF_0000_4000_C000, BY_MODEL, 16'h0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [FRAME_W-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;
  logic                out_tlast;
  logic                cfg_wr_en = 1'b0;
  logic [0:0]          cfg_index = dlr_pkg::REG_CHANNEL_COUNT;
  logic [PHASE_W-1:0]  cfg_wdata = '0;

  // Model copy of the registers and the resampler state
  logic [COUNT_W-1:0]  count_cfg;
  logic [PHASE_W-1:0]  step_cfg;
  logic [PHASE_W-1:0]  phase_acc_q;
  int                  prev_mono_q;

  mono_sample_t        pending_samples[$];
  mono_sample_t        head_sample;
  int                  n_fail = 0;
  bit                  no_idle = 1'b0;

  downmix_linear_resampler #(
    .MAX_CHANNELS(MAX_CH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Average the active channels, then walk the phase and queue the samples
  function automatic int downmix_and_resample(input logic [FRAME_W-1:0] frame,
                                              input bit queue_it);
    int          cnt;
    int unsigned step;
    int unsigned ph;
    int          sum;
    int          mono;
    int          n;
    longint      diff;
    longint      val;
    mono_sample_t s;
    cnt = int'(count_cfg);
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_CH) cnt = MAX_CH;
    step = 32'(step_cfg);
    if (step < dlr_pkg::MIN_STEP) step = 32'(dlr_pkg::MIN_STEP);
    sum = 0;
    for (int ch = 0; ch < cnt; ch++) begin
      sum += int'($signed(frame[ch*SAMPLE_W +: SAMPLE_W]));
    end
    mono = sum / cnt;
    diff = longint'(mono) - longint'(prev_mono_q);
    ph = 32'(phase_acc_q);
    n = 0;
    while (ph < dlr_pkg::ONE_Q16 && n < MAX_RESULTS) begin
      // arithmetic shift floors toward minus infinity
      val = longint'(prev_mono_q) + ((longint'(ph) * diff) >>> 16);
      s.mono = val[SAMPLE_W-1:0];
      s.last = 1'b0;
      if (queue_it) pending_samples.push_back(s);
      n++;
      ph += step;
    end
    if (queue_it && n > 0) pending_samples[pending_samples.size()-1].last = 1'b1;
    phase_acc_q = PHASE_W'(ph - dlr_pkg::ONE_Q16);
    prev_mono_q = mono;
    return n;
  endfunction

  // Present one frame, hold it until accepted, then predict its samples
  task automatic send_frame(input logic [FRAME_W-1:0] frame, input int n_fixed,
                            input logic [SAMPLE_W-1:0] fixed_mono);
    int n;
    mono_sample_t s;
    if (!no_idle && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < 29);
    end
    in_tdata  <= frame;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = downmix_and_resample(frame, n_fixed < 0);
    for (int i = 0; i < n_fixed; i++) begin
      s.mono = fixed_mono;
      s.last = (i == n_fixed - 1);
      pending_samples.push_back(s);
    end
  endtask

  // Drop valid, wait for every predicted word, then let the sequencer finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles
  task automatic set_config(input logic [COUNT_W-1:0] cnt, input logic [PHASE_W-1:0] step);
    cfg_wr_en <= 1'b1;
    cfg_index <= dlr_pkg::REG_CHANNEL_COUNT;
    cfg_wdata <= PHASE_W'(cnt);
    @(posedge clk);
    cfg_index <= dlr_pkg::REG_RESAMPLE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    count_cfg = cnt;
    step_cfg  = step;
  endtask

  // Output side backpressure
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 29);
  end

  // Compare each output word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected word: mono_out %0d, run_end %0b", $signed(out_tdata), out_tlast);
        n_fail++;
      end else begin
        head_sample = pending_samples.pop_front();
        if (out_tdata !== head_sample.mono) begin
          $error("mono_out: expected %0d, actual %0d",
                 $signed(head_sample.mono), $signed(out_tdata));
          n_fail++;
        end
        if (out_tlast !== head_sample.last) begin
          $error("run_end: expected %0b, actual %0b", head_sample.last, out_tlast);
          n_fail++;
        end
      end
    end
  end

  initial begin
    logic [FRAME_W-1:0]  frame;
    logic [SAMPLE_W-1:0] lane;
    logic [COUNT_W-1:0]  cnt;
    logic [PHASE_W-1:0]  step;
    int                  k;
    int                  left_in_setting;
    count_cfg   = dlr_pkg::COUNT_RESET;
    step_cfg    = dlr_pkg::STEP_RESET;
    phase_acc_q = '0;
    prev_mono_q = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < N_DIR; r++) begin
      if (DIRECTED[r].kind == ROW_CONFIG) begin
        wait_idle();
        set_config(DIRECTED[r].count, DIRECTED[r].step);
      end else begin
        send_frame(DIRECTED[r].frame, int'(DIRECTED[r].n_fixed), DIRECTED[r].fixed_mono);
      end
    end

    // Random frames, new settings every few dozen frames
    k = 0;
    left_in_setting = 0;
    while (k < RAND_ITEMS) begin
      if (left_in_setting == 0) begin
        wait_idle();
        if ($urandom_range(9) < 7) cnt = COUNT_W'($urandom_range(1, MAX_CH));
        else cnt = COUNT_W'($urandom_range(0, 15));
        case ($urandom_range(9))
          0: step = dlr_pkg::MIN_STEP;
          1: step = PHASE_W'(dlr_pkg::ONE_Q16);
          2: step = 21'd1048576;
          3: step = PHASE_W'($urandom_range(0, 4095));
          4: step = PHASE_W'($urandom_range(1048577, 2097151));
          default: step = PHASE_W'($urandom_range(4096, 262144));
        endcase
        set_config(cnt, step);
        left_in_setting = $urandom_range(20, 80);
      end
      no_idle = (k >= 150 && k < 250);
      for (int ch = 0; ch < MAX_CH; ch++) begin
        if ($urandom_range(7) == 0) lane = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        else lane = SAMPLE_W'($urandom);
        frame[ch*SAMPLE_W +: SAMPLE_W] = lane;
      end
      send_frame(frame, BY_MODEL, '0);
      k++;
      left_in_setting--;
    end

    wait_idle();
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
